FILE: rtl/core/opc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and lookup functions of the expression checker.
package opc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;

    // Lexer tokens
    typedef enum logic [2:0] {
        TK_BAD    = 3'd0,
        TK_PLUS   = 3'd1,
        TK_MINUS  = 3'd2,
        TK_MULDIV = 3'd3,
        TK_ID     = 3'd4,
        TK_LP     = 3'd5,
        TK_RP     = 3'd6,
        TK_END    = 3'd7
    } tok_t;

    // Parse stack symbols; SYM_E is the reduced nonterminal
    typedef enum logic [2:0] {
        SYM_E   = 3'd0,
        SYM_ADD = 3'd1,
        SYM_MUL = 3'd2,
        SYM_ID  = 3'd3,
        SYM_LP  = 3'd4,
        SYM_RP  = 3'd5,
        SYM_END = 3'd6
    } sym_t;

    typedef enum logic [1:0] {
        REL_LT   = 2'd0,
        REL_EQ   = 2'd1,
        REL_GT   = 2'd2,
        REL_NONE = 2'd3
    } rel_t;

    typedef enum logic [2:0] {
        V_ACCEPT    = 3'd0,
        V_BAD_START = 3'd1,
        V_ADJ_OPS   = 3'd2,
        V_OP_CLOSE  = 3'd3,
        V_PAREN_OP  = 3'd4,
        V_NO_REL    = 3'd5,
        V_BAD_CHAR  = 3'd6,
        V_OVERFLOW  = 3'd7
    } verdict_t;

    typedef struct packed {
        logic start;
        logic clear;
        tok_t tok;
        logic next_op;
    } eng_ctrl_t;

    typedef struct packed {
        logic     done;
        logic     hit;
        verdict_t code;
    } eng_stat_t;

    function automatic logic is_op(tok_t t);
        return (t == TK_PLUS) || (t == TK_MINUS) || (t == TK_MULDIV);
    endfunction

    function automatic sym_t tok_class(tok_t t);
        sym_t s;
        s = SYM_E;
        unique case (t) inside
            TK_PLUS, TK_MINUS: s = SYM_ADD;
            TK_MULDIV:         s = SYM_MUL;
            TK_ID:             s = SYM_ID;
            TK_LP:             s = SYM_LP;
            TK_RP:             s = SYM_RP;
            TK_END:            s = SYM_END;
            default:           s = SYM_E;
        endcase
        return s;
    endfunction

    // Precedence of stack symbol a against incoming symbol b
    function automatic rel_t relation(sym_t a, sym_t b);
        rel_t r;
        r = REL_NONE;
        unique case (a) inside
            SYM_ADD:
            begin
                unique case (b) inside
                    SYM_ADD, SYM_RP, SYM_END: r = REL_GT;
                    SYM_MUL, SYM_ID, SYM_LP:  r = REL_LT;
                    default:                  r = REL_NONE;
                endcase
            end
            SYM_MUL:
            begin
                unique case (b) inside
                    SYM_ADD, SYM_MUL, SYM_RP, SYM_END: r = REL_GT;
                    SYM_ID, SYM_LP:                    r = REL_LT;
                    default:                           r = REL_NONE;
                endcase
            end
            SYM_ID, SYM_RP:
            begin
                unique case (b) inside
                    SYM_ADD, SYM_MUL, SYM_RP, SYM_END: r = REL_GT;
                    default:                           r = REL_NONE;
                endcase
            end
            SYM_LP:
            begin
                unique case (b) inside
                    SYM_ADD, SYM_MUL, SYM_ID, SYM_LP: r = REL_LT;
                    SYM_RP:                           r = REL_EQ;
                    default:                          r = REL_NONE;
                endcase
            end
            SYM_END:
            begin
                unique case (b) inside
                    SYM_ADD, SYM_MUL, SYM_ID, SYM_LP: r = REL_LT;
                    SYM_END:                          r = REL_EQ;
                    default:                          r = REL_NONE;
                endcase
            end
            default: r = REL_NONE;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/opc_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for expression characters and verdicts.
interface opc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_expr;

    modport source (output valid, output ch, output end_of_expr, input ready);
    modport sink (input valid, input ch, input end_of_expr, output ready);
endinterface

interface opc_verdict_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

FILE: rtl/core/operator_precedence_expr_checker.sv
`timescale 1ns / 1ps
// Operator-precedence expression checker: one character word in, at most one verdict word out.
// A character word that completes no token, or completes the first token of an expression,
// is taken while ready stays high. A word that completes a later token hands the held token
// to the precedence engine, and ready stays low until the engine finishes: pair checks, which
// may give a verdict, then shifts and reductions; each reduction walks the handle one terminal
// at a time, because every stack walk step goes through the single registered read port of
// the stack memory (STACK_DEPTH entries). A verdict passes from the engine's status registers
// through the emit step into the output register. The end word runs the held token and then
// the end marker (the marker is skipped if the held token gives a verdict), then gives its
// verdict and resets the parser; a verdict that waits in the output register holds the block
// until it is taken.
module operator_precedence_expr_checker (
    input logic          clk,
    input logic          rst_n,
    opc_char_if.sink     chars,
    opc_verdict_if.source result
);

    typedef enum logic [4:0] {
        T_IDLE     = 5'b00001,
        T_RUN      = 5'b00010,
        T_HELD_END = 5'b00100,
        T_END      = 5'b01000,
        T_EMIT     = 5'b10000
    } top_state_t;

    top_state_t         state_reg, state_next;
    opc_pkg::tok_t      held_tok_reg, held_tok_next;
    logic               held_valid_reg, held_valid_next;
    logic               verdict_given_reg, verdict_given_next;
    opc_pkg::verdict_t  pend_code_reg, pend_code_next;
    logic               pend_reset_reg, pend_reset_next;
    logic               out_valid_reg, out_valid_next;
    opc_pkg::verdict_t  out_verdict_reg, out_verdict_next;

    logic               accept;
    logic               lex_step;
    logic               lex_clear;
    opc_pkg::tok_t      lex_tok;
    logic               lex_have;
    opc_pkg::eng_ctrl_t eng_ctrl;
    opc_pkg::eng_stat_t eng_stat;

    assign chars.ready = (state_reg == T_IDLE);
    assign accept      = chars.valid && chars.ready;
    assign lex_step    = accept && !chars.end_of_expr && !verdict_given_reg;
    assign lex_clear   = accept && chars.end_of_expr;

    opc_lexer u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch       (chars.ch),
        .step     (lex_step),
        .clear    (lex_clear),
        .tok      (lex_tok),
        .have_tok (lex_have)
    );

    opc_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (eng_ctrl),
        .stat  (eng_stat)
    );

    always_comb
    begin
        state_next         = state_reg;
        held_tok_next      = held_tok_reg;
        held_valid_next    = held_valid_reg;
        verdict_given_next = verdict_given_reg;
        pend_code_next     = pend_code_reg;
        pend_reset_next    = pend_reset_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        out_verdict_next   = out_verdict_reg;
        eng_ctrl.start     = 1'b0;
        eng_ctrl.clear     = 1'b0;
        eng_ctrl.tok       = held_tok_reg;
        eng_ctrl.next_op   = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (chars.end_of_expr)
                    begin
                        if (verdict_given_reg)
                        begin
                            // verdict already out: drop the word and reset
                            eng_ctrl.clear     = 1'b1;
                            held_valid_next    = 1'b0;
                            verdict_given_next = 1'b0;
                        end
                        else if (held_valid_reg)
                        begin
                            eng_ctrl.start = 1'b1;
                            state_next     = T_HELD_END;
                        end
                        else
                        begin
                            eng_ctrl.start = 1'b1;
                            eng_ctrl.tok   = opc_pkg::TK_END;
                            state_next     = T_END;
                        end
                    end
                    else if (!verdict_given_reg && lex_have)
                    begin
                        if (held_valid_reg)
                        begin
                            eng_ctrl.start   = 1'b1;
                            eng_ctrl.next_op = opc_pkg::is_op(lex_tok);
                            state_next       = T_RUN;
                        end
                        held_tok_next   = lex_tok;
                        held_valid_next = 1'b1;
                    end
                end
            end
            T_RUN:
            begin
                if (eng_stat.done)
                begin
                    if (eng_stat.hit)
                    begin
                        verdict_given_next = 1'b1;
                        pend_code_next     = eng_stat.code;
                        pend_reset_next    = 1'b0;
                        state_next         = T_EMIT;
                    end
                    else
                    begin
                        state_next = T_IDLE;
                    end
                end
            end
            T_HELD_END:
            begin
                if (eng_stat.done)
                begin
                    if (eng_stat.hit)
                    begin
                        pend_code_next  = eng_stat.code;
                        pend_reset_next = 1'b1;
                        state_next      = T_EMIT;
                    end
                    else
                    begin
                        eng_ctrl.start = 1'b1;
                        eng_ctrl.tok   = opc_pkg::TK_END;
                        state_next     = T_END;
                    end
                end
            end
            T_END:
            begin
                if (eng_stat.done)
                begin
                    pend_code_next  = eng_stat.hit ? eng_stat.code : opc_pkg::V_NO_REL;
                    pend_reset_next = 1'b1;
                    state_next      = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = pend_code_reg;
                    if (pend_reset_reg)
                    begin
                        eng_ctrl.clear     = 1'b1;
                        held_valid_next    = 1'b0;
                        verdict_given_next = 1'b0;
                    end
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_IDLE;
            held_valid_reg    <= 1'b0;
            verdict_given_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            held_valid_reg    <= held_valid_next;
            verdict_given_reg <= verdict_given_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_tok_reg    <= held_tok_next;
        pend_code_reg   <= pend_code_next;
        pend_reset_reg  <= pend_reset_next;
        out_verdict_reg <= out_verdict_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.verdict = out_verdict_reg;

    a_done_when_waiting : assert property (@(posedge clk) disable iff (!rst_n)
        eng_stat.done |-> (state_reg == T_RUN || state_reg == T_HELD_END
                           || state_reg == T_END))
        else $error("engine finished while no token was in flight");

    a_end_after_verdict_resets : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.end_of_expr && verdict_given_reg)
        |=> (!verdict_given_reg && !held_valid_reg && state_reg == T_IDLE))
        else $error("end word after a verdict did not reset the parser");

    a_result_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_EMIT))
        else $error("verdict word appeared outside the emit step");

endmodule

FILE: rtl/core/opc_lexer.sv
`timescale 1ns / 1ps
// Character lexer: folds digit runs and identifiers into operand tokens.
module opc_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    ch,
    input  logic          step,
    input  logic          clear,
    output opc_pkg::tok_t tok,
    output logic          have_tok
);

    typedef enum logic [2:0] {
        LX_OUT   = 3'b001,
        LX_NUM   = 3'b010,
        LX_IDENT = 3'b100
    } lex_mode_t;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_HASH  = 8'h23;

    lex_mode_t mode_reg;
    lex_mode_t mode_next;
    logic      is_digit;
    logic      is_alpha;

    always_comb
    begin
        is_digit  = (ch >= CH_0) && (ch <= CH_9);
        is_alpha  = (ch == CH_UNDER) || ((ch >= CH_LA) && (ch <= CH_LZ))
                    || ((ch >= CH_UA) && (ch <= CH_UZ));
        mode_next = mode_reg;
        tok       = opc_pkg::TK_BAD;
        have_tok  = 1'b1;
        if (is_digit)
        begin
            tok = opc_pkg::TK_ID;
            if (mode_reg == LX_OUT)
            begin
                mode_next = LX_NUM;
            end
            else
            begin
                have_tok = 1'b0;
            end
        end
        else if (is_alpha)
        begin
            tok = opc_pkg::TK_ID;
            // a letter after a digit run starts a new operand
            if (mode_reg == LX_IDENT)
            begin
                have_tok = 1'b0;
            end
            else
            begin
                mode_next = LX_IDENT;
            end
        end
        else
        begin
            mode_next = LX_OUT;
            case (ch) inside
                CH_PLUS:           tok = opc_pkg::TK_PLUS;
                CH_MINUS:          tok = opc_pkg::TK_MINUS;
                CH_STAR, CH_SLASH: tok = opc_pkg::TK_MULDIV;
                CH_LP:             tok = opc_pkg::TK_LP;
                CH_RP:             tok = opc_pkg::TK_RP;
                CH_HASH:           tok = opc_pkg::TK_END;
                default:           tok = opc_pkg::TK_BAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= LX_OUT;
        end
        else if (clear)
        begin
            mode_reg <= LX_OUT;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

FILE: rtl/core/opc_engine.sv
`timescale 1ns / 1ps
// Precedence engine: pair checks, then shift/reduce steps over the stack memory.
module opc_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  opc_pkg::eng_ctrl_t ctrl,
    output opc_pkg::eng_stat_t stat
);

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_KEY   = 6'b000010,
        E_KEYRD = 6'b000100,
        E_WALKA = 6'b001000,
        E_WALKB = 6'b010000,
        E_WALKC = 6'b100000
    } eng_state_t;

    eng_state_t         state_reg, state_next;
    opc_pkg::ptr_t      top_reg, top_next;
    opc_pkg::sym_t      top_sym_reg, top_sym_next;
    opc_pkg::sym_t      cls_reg, cls_next;
    opc_pkg::ptr_t      k_reg, k_next;
    opc_pkg::sym_t      t_reg, t_next;
    logic               first_reg, first_next;
    logic               prev_op_reg, prev_op_next;
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    opc_pkg::verdict_t  code_reg, code_next;

    opc_pkg::sym_t      stack_mem [opc_pkg::STACK_DEPTH];
    opc_pkg::sym_t      rdata_reg;
    logic               rd_one_reg;
    opc_pkg::sym_t      rd_sym;
    logic               we;
    opc_pkg::ptr_t      waddr;
    opc_pkg::sym_t      wdata;
    opc_pkg::ptr_t      raddr;

    opc_pkg::sym_t      dec_sym;
    opc_pkg::ptr_t      dec_key;
    opc_pkg::ptr_t      ev_k;
    logic               in_walk;
    opc_pkg::sym_t      rel_a, rel_b;
    opc_pkg::rel_t      rel;
    logic               decide, eval, push, fin, quit;
    opc_pkg::verdict_t  fin_code;

    // reads of the bottom entry always return the end marker
    assign rd_sym = rd_one_reg ? opc_pkg::SYM_END : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= wdata;
        end
        rdata_reg  <= stack_mem[raddr];
        rd_one_reg <= (raddr == opc_pkg::ptr_t'(1));
    end

    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        top_sym_next = top_sym_reg;
        cls_next     = cls_reg;
        k_next       = k_reg;
        t_next       = t_reg;
        first_next   = first_reg;
        prev_op_next = prev_op_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        code_next    = code_reg;
        we           = 1'b0;
        waddr        = top_reg + opc_pkg::ptr_t'(1);
        wdata        = cls_reg;
        raddr        = k_reg - opc_pkg::ptr_t'(1);
        decide       = 1'b0;
        eval         = 1'b0;
        push         = 1'b0;
        fin          = 1'b0;
        quit         = 1'b0;
        fin_code     = opc_pkg::V_NO_REL;

        in_walk = (state_reg == E_WALKB) || (state_reg == E_WALKC);
        dec_sym = (state_reg == E_KEYRD) ? rd_sym : top_sym_reg;
        dec_key = (state_reg == E_KEYRD) ? (top_reg - opc_pkg::ptr_t'(1)) : top_reg;
        ev_k    = (state_reg == E_WALKB) ? (k_reg - opc_pkg::ptr_t'(1))
                                         : (k_reg - opc_pkg::ptr_t'(2));
        // one shared precedence lookup
        rel_a   = in_walk ? rd_sym : dec_sym;
        rel_b   = in_walk ? t_reg : cls_reg;
        rel     = opc_pkg::relation(rel_a, rel_b);

        unique case (state_reg)
            E_IDLE:
            begin
                if (ctrl.clear)
                begin
                    top_next     = opc_pkg::ptr_t'(1);
                    top_sym_next = opc_pkg::SYM_END;
                    first_next   = 1'b0;
                    prev_op_next = 1'b0;
                end
                else if (ctrl.start)
                begin
                    first_next = 1'b1;
                    if (!first_reg && !((ctrl.tok == opc_pkg::TK_ID)
                        || (ctrl.tok == opc_pkg::TK_LP) || (ctrl.tok == opc_pkg::TK_MINUS)))
                    begin
                        fin      = 1'b1;
                        fin_code = opc_pkg::V_BAD_START;
                    end
                    else if (opc_pkg::is_op(ctrl.tok) && ctrl.next_op)
                    begin
                        fin      = 1'b1;
                        fin_code = opc_pkg::V_ADJ_OPS;
                    end
                    else if (((ctrl.tok == opc_pkg::TK_END) || (ctrl.tok == opc_pkg::TK_RP))
                             && prev_op_reg)
                    begin
                        fin      = 1'b1;
                        fin_code = opc_pkg::V_OP_CLOSE;
                    end
                    else if ((ctrl.tok == opc_pkg::TK_LP) && ctrl.next_op)
                    begin
                        fin      = 1'b1;
                        fin_code = opc_pkg::V_PAREN_OP;
                    end
                    else
                    begin
                        prev_op_next = opc_pkg::is_op(ctrl.tok);
                        if (ctrl.tok == opc_pkg::TK_BAD)
                        begin
                            fin      = 1'b1;
                            fin_code = opc_pkg::V_BAD_CHAR;
                        end
                        else
                        begin
                            cls_next   = opc_pkg::tok_class(ctrl.tok);
                            state_next = E_KEY;
                        end
                    end
                end
            end
            E_KEY:
            begin
                // skip a nonterminal on top: fetch the entry below
                if (top_sym_reg == opc_pkg::SYM_E)
                begin
                    raddr      = top_reg - opc_pkg::ptr_t'(1);
                    state_next = E_KEYRD;
                end
                else
                begin
                    decide = 1'b1;
                end
            end
            E_KEYRD:
            begin
                decide = 1'b1;
            end
            E_WALKA:
            begin
                if (k_reg < opc_pkg::ptr_t'(2))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    raddr      = k_reg - opc_pkg::ptr_t'(1);
                    state_next = E_WALKB;
                end
            end
            E_WALKB:
            begin
                if (rd_sym != opc_pkg::SYM_E)
                begin
                    eval = 1'b1;
                end
                else if (k_reg < opc_pkg::ptr_t'(3))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    raddr      = k_reg - opc_pkg::ptr_t'(2);
                    state_next = E_WALKC;
                end
            end
            E_WALKC:
            begin
                if (rd_sym == opc_pkg::SYM_E)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    eval = 1'b1;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (decide)
        begin
            if ((dec_key == '0) || (dec_sym == opc_pkg::SYM_E))
            begin
                fin = 1'b1;
            end
            else
            begin
                case (rel)
                    opc_pkg::REL_LT: push = 1'b1;
                    opc_pkg::REL_EQ:
                    begin
                        if (dec_sym == opc_pkg::SYM_END)
                        begin
                            fin      = 1'b1;
                            fin_code = opc_pkg::V_ACCEPT;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    opc_pkg::REL_GT:
                    begin
                        k_next     = dec_key;
                        t_next     = dec_sym;
                        state_next = E_WALKA;
                    end
                    default: fin = 1'b1;
                endcase
            end
        end

        if (eval)
        begin
            if (rel == opc_pkg::REL_LT)
            begin
                // handle found: collapse it into one nonterminal
                top_next     = ev_k + opc_pkg::ptr_t'(1);
                we           = 1'b1;
                waddr        = ev_k + opc_pkg::ptr_t'(1);
                wdata        = opc_pkg::SYM_E;
                top_sym_next = opc_pkg::SYM_E;
                state_next   = E_KEY;
            end
            else
            begin
                t_next     = rd_sym;
                k_next     = ev_k;
                state_next = E_WALKA;
            end
        end

        if (push)
        begin
            if (top_reg == opc_pkg::ptr_t'(opc_pkg::STACK_DEPTH - 1))
            begin
                fin      = 1'b1;
                fin_code = opc_pkg::V_OVERFLOW;
            end
            else
            begin
                we           = 1'b1;
                waddr        = top_reg + opc_pkg::ptr_t'(1);
                wdata        = cls_reg;
                top_next     = top_reg + opc_pkg::ptr_t'(1);
                top_sym_next = cls_reg;
                quit         = 1'b1;
            end
        end

        if (fin)
        begin
            done_next  = 1'b1;
            hit_next   = 1'b1;
            code_next  = fin_code;
            state_next = E_IDLE;
        end
        else if (quit)
        begin
            done_next  = 1'b1;
            hit_next   = 1'b0;
            state_next = E_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            top_reg     <= opc_pkg::ptr_t'(1);
            top_sym_reg <= opc_pkg::SYM_END;
            first_reg   <= 1'b0;
            prev_op_reg <= 1'b0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            top_sym_reg <= top_sym_next;
            first_reg   <= first_next;
            prev_op_reg <= prev_op_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg  <= cls_next;
        k_reg    <= k_next;
        t_reg    <= t_next;
        code_reg <= code_next;
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;
    assign stat.code = code_reg;

endmodule
